// File: src/kslseq_pkg.sv
// Package for the keyboard status lamp sequencer: item, result and register types,
// register reset values, lamp bit positions and the breathing table.
// No dependencies.
package kslseq_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgPowerOffTicks    = 3'd0,
    CfgPairArmTicks     = 3'd1,
    CfgPairTimeoutTicks = 3'd2,
    CfgStatusDivider    = 3'd3,
    CfgBootDisplay      = 3'd4,
    CfgLowBatteryPct    = 3'd5,
    CfgCritBatteryPct   = 3'd6
  } cfg_reg_e;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 12;

  typedef enum logic [1:0] {
    HaltRun     = 2'd0,
    HaltManual  = 2'd1,
    HaltBattery = 2'd2
  } halt_e;

  // Lamp bit positions in the stored lamp word
  localparam int LampBt    = 0;
  localparam int LampRed   = 1;
  localparam int LampGreen = 2;
  localparam int LampMute  = 3;
  localparam int LampMic   = 4;
  localparam int LampW     = 5;

  localparam logic [7:0]  PowerOffTicksRst    = 8'd100;
  localparam logic [7:0]  PairArmTicksRst     = 8'd25;
  localparam logic [11:0] PairTimeoutTicksRst = 12'd1125;
  localparam logic [3:0]  StatusDividerRst    = 4'd6;
  localparam logic [6:0]  BootDisplayRst      = 7'd10;
  localparam logic [6:0]  LowBatteryPctRst    = 7'd10;
  localparam logic [6:0]  CritBatteryPctRst   = 7'd2;

  localparam logic [6:0] DutyFull      = 7'd100;
  localparam logic [6:0] PeriodsMax    = 7'd127;
  localparam logic [7:0] CountMax      = 8'd255;

  localparam int BreathStepsDefault = 50;
  localparam int BreathRomDepth     = 64;
  localparam int BreathRomIdxW      = 6;

  typedef struct packed {
    logic       power_key_down;
    logic       fn_layer_held;
    logic       link_up;
    logic [6:0] battery_level;
    logic       usb_power;
    logic       device_idle;
    logic       charger_busy;
    logic       mute_key_press;
    logic       mic_key_press;
  } item_t;

  typedef struct packed {
    logic       bt_lamp;
    logic       red_lamp;
    logic       green_lamp;
    logic       mute_lamp;
    logic       mic_lamp;
    logic [6:0] power_duty;
    logic [1:0] shutdown_code;
    logic       pairing_on;
    logic       clear_bonds;
  } result_t;

  typedef struct packed {
    logic [7:0]  power_off_ticks;
    logic [7:0]  pair_arm_ticks;
    logic [11:0] pair_timeout_ticks;
    logic [3:0]  status_divider;
    logic [6:0]  boot_display_periods;
    logic [6:0]  low_battery_pct;
    logic [6:0]  critical_battery_pct;
  } cfg_t;

  // Breathing curve; entries past the defined steps are dark
  function automatic logic [6:0] breath_duty(input logic [BreathRomIdxW-1:0] idx);
    logic [6:0] duty;
    case (idx)
      6'd1:    duty = 7'd2;
      6'd2:    duty = 7'd8;
      6'd3:    duty = 7'd18;
      6'd4:    duty = 7'd32;
      6'd5:    duty = 7'd50;
      6'd6:    duty = 7'd68;
      6'd7:    duty = 7'd82;
      6'd8:    duty = 7'd92;
      6'd9:    duty = 7'd98;
      6'd10:   duty = 7'd100;
      6'd11:   duty = 7'd98;
      6'd12:   duty = 7'd92;
      6'd13:   duty = 7'd82;
      6'd14:   duty = 7'd68;
      6'd15:   duty = 7'd50;
      6'd16:   duty = 7'd32;
      6'd17:   duty = 7'd18;
      6'd18:   duty = 7'd8;
      6'd19:   duty = 7'd2;
      default: duty = 7'd0;
    endcase
    return duty;
  endfunction

endpackage

// File: src/kslseq_if.sv
// Handshake channels of the keyboard status lamp sequencer: tick items, results
// and configuration writes. Depends on kslseq_pkg.

interface kslseq_item_if;
  logic                 valid;
  logic                 ready;
  kslseq_pkg::item_t    item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface kslseq_result_if;
  logic                 valid;
  logic                 ready;
  kslseq_pkg::result_t  result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface kslseq_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kslseq_pkg::CfgAddrW-1:0]     addr;
  logic [kslseq_pkg::CfgDataW-1:0]     wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: src/kslseq_step.sv
// Per-tick state update of the lamp sequencer: shutdown checks, pairing machine,
// breathing index and status lamp refresh. Depends on kslseq_pkg.
module kslseq_step #(
  parameter int BreathSteps = kslseq_pkg::BreathStepsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  kslseq_pkg::cfg_t    cfg_i,
  input  kslseq_pkg::item_t   item_i,
  output kslseq_pkg::result_t res_o
);

  localparam int IdxW = (BreathSteps > 1) ? $clog2(BreathSteps) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(BreathSteps - 1);

  logic [7:0]              press_q, press_d;
  logic                    pair_q, pair_d;
  logic [7:0]              arm_q, arm_d;
  logic [11:0]             tmo_q, tmo_d;
  logic                    pair_last_q, pair_last_d;
  logic                    blink_q, blink_d;
  logic                    toggle_q, toggle_d;
  logic [3:0]              phase_q, phase_d;
  logic [6:0]              periods_q, periods_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [kslseq_pkg::LampW-1:0] lamp_q, lamp_d;
  kslseq_pkg::halt_e       halt_q, halt_d;

  logic [6:0] duty;
  logic       bonds;
  logic [3:0] div;
  logic       low;

  always_comb begin
    press_d     = press_q;
    pair_d      = pair_q;
    arm_d       = arm_q;
    tmo_d       = tmo_q;
    pair_last_d = pair_last_q;
    blink_d     = blink_q;
    toggle_d    = toggle_q;
    phase_d     = phase_q;
    periods_d   = periods_q;
    idx_d       = idx_q;
    lamp_d      = lamp_q;
    halt_d      = halt_q;
    duty        = '0;
    bonds       = 1'b0;
    div         = (cfg_i.status_divider == 4'd0) ? 4'd1 : cfg_i.status_divider;
    low         = item_i.battery_level < cfg_i.low_battery_pct;

    if (halt_q == kslseq_pkg::HaltRun) begin
      if (item_i.mute_key_press) lamp_d[kslseq_pkg::LampMute] = ~lamp_d[kslseq_pkg::LampMute];
      if (item_i.mic_key_press)  lamp_d[kslseq_pkg::LampMic]  = ~lamp_d[kslseq_pkg::LampMic];
      if (item_i.power_key_down) begin
        if (press_q != kslseq_pkg::CountMax) press_d = press_q + 8'd1;
        if (press_d >= cfg_i.power_off_ticks) halt_d = kslseq_pkg::HaltManual;
      end else begin
        press_d = '0;
      end
      if (halt_d == kslseq_pkg::HaltRun && !item_i.usb_power &&
          item_i.battery_level < cfg_i.critical_battery_pct) begin
        halt_d = kslseq_pkg::HaltBattery;
      end
    end

    if (halt_d != kslseq_pkg::HaltRun) begin
      lamp_d = '0;
      pair_d = 1'b0;
    end else begin
      // pairing machine
      if (!pair_q) begin
        if (item_i.fn_layer_held && item_i.power_key_down) begin
          if (arm_q == 8'd0) begin
            arm_d = 8'd1;
          end else if (arm_q >= cfg_i.pair_arm_ticks) begin
            pair_d = 1'b1;
            bonds  = 1'b1;
            tmo_d  = cfg_i.pair_timeout_ticks;
            arm_d  = '0;
          end else if (arm_q != kslseq_pkg::CountMax) begin
            arm_d = arm_q + 8'd1;
          end
        end else begin
          arm_d = '0;
        end
      end else begin
        if (tmo_q != 12'd0) tmo_d = tmo_q - 12'd1;
        if (item_i.link_up || tmo_d == 12'd0) pair_d = 1'b0;
      end

      if (pair_last_q && !pair_d) begin
        lamp_d[kslseq_pkg::LampMute] = 1'b0;
        lamp_d[kslseq_pkg::LampMic]  = 1'b0;
      end
      pair_last_d = pair_d;

      if (pair_d) begin
        blink_d = ~blink_q;
        lamp_d[kslseq_pkg::LampBt]   = blink_d;
        lamp_d[kslseq_pkg::LampMute] = blink_d;
        lamp_d[kslseq_pkg::LampMic]  = blink_d;
        duty  = blink_d ? kslseq_pkg::DutyFull : 7'd0;
        idx_d = '0;
      end else begin
        duty  = kslseq_pkg::breath_duty(kslseq_pkg::BreathRomIdxW'(idx_q));
        idx_d = (idx_q == IdxLast) ? '0 : idx_q + IdxW'(1);
      end

      // status lamps refresh at each divider period start unless pairing
      phase_d = (phase_q >= div) ? 4'd0 : phase_q;
      if (phase_d == 4'd0 && !pair_d) begin
        if (item_i.device_idle)  lamp_d[kslseq_pkg::LampBt] = 1'b0;
        else if (item_i.link_up) lamp_d[kslseq_pkg::LampBt] = 1'b1;
        else                     lamp_d[kslseq_pkg::LampBt] = toggle_q;

        if (item_i.usb_power) begin
          lamp_d[kslseq_pkg::LampRed]   = item_i.charger_busy;
          lamp_d[kslseq_pkg::LampGreen] = ~item_i.charger_busy;
        end else if (periods_q < cfg_i.boot_display_periods && !item_i.device_idle) begin
          lamp_d[kslseq_pkg::LampRed]   = low;
          lamp_d[kslseq_pkg::LampGreen] = ~low;
        end else begin
          lamp_d[kslseq_pkg::LampRed]   = 1'b0;
          lamp_d[kslseq_pkg::LampGreen] = 1'b0;
        end
        toggle_d = ~toggle_q;
      end
      phase_d = phase_d + 4'd1;
      if (phase_d >= div) begin
        phase_d = 4'd0;
        if (periods_q != kslseq_pkg::PeriodsMax) periods_d = periods_q + 7'd1;
      end
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.shutdown_code = halt_d;
    if (halt_d == kslseq_pkg::HaltRun) begin
      res_o.bt_lamp    = lamp_d[kslseq_pkg::LampBt];
      res_o.red_lamp   = lamp_d[kslseq_pkg::LampRed];
      res_o.green_lamp = lamp_d[kslseq_pkg::LampGreen];
      res_o.mute_lamp  = lamp_d[kslseq_pkg::LampMute];
      res_o.mic_lamp   = lamp_d[kslseq_pkg::LampMic];
      res_o.power_duty = duty;
      res_o.pairing_on = pair_d;
      res_o.clear_bonds = bonds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= '0;
      pair_q      <= 1'b0;
      arm_q       <= '0;
      tmo_q       <= '0;
      pair_last_q <= 1'b0;
      blink_q     <= 1'b0;
      toggle_q    <= 1'b0;
      phase_q     <= '0;
      periods_q   <= '0;
      idx_q       <= '0;
      lamp_q      <= '0;
      halt_q      <= kslseq_pkg::HaltRun;
    end else if (adv_i) begin
      press_q     <= press_d;
      pair_q      <= pair_d;
      arm_q       <= arm_d;
      tmo_q       <= tmo_d;
      pair_last_q <= pair_last_d;
      blink_q     <= blink_d;
      toggle_q    <= toggle_d;
      phase_q     <= phase_d;
      periods_q   <= periods_d;
      idx_q       <= idx_d;
      lamp_q      <= lamp_d;
      halt_q      <= halt_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a shutdown never clears short of reset
  a_halt_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q != kslseq_pkg::HaltRun |=> halt_q == $past(halt_q))
    else $error("shutdown code changed after latching");

  // pairing only entered with a bond clear on the same tick
  a_pair_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !pair_q && pair_d |-> bonds)
    else $error("pairing entered without clear_bonds");

  // breathing index stays inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxLast)
    else $error("breathing index out of range");
`endif

endmodule

// File: src/keyboard_status_led_sequencer_core.sv
// Top level of the keyboard status lamp sequencer: channels, configuration
// registers and the input and result registers.
// Depends on kslseq_pkg, kslseq_if and kslseq_step.
//
// Usage: send one item on in_i per 80 ms tick with the key, link, battery and
// supply levels. Each item gives exactly one result on out_o with the lamp
// states, the power LED duty in percent, the shutdown code, pairing status and
// the one-tick clear_bonds pulse.
// Configuration writes go on cfg_i (addr is the register index, wdata the value);
// cfg_i.ready is always high. Write registers only while no item is in flight.
// Path: an accepted item waits in the input register; its result enters the
// result register unless that register is still held by a stalled result.
// Throughput: one item per cycle while out_o.ready is high; the state update
// is one pass of logic between the input register and the result register.
// Stall: while out_o.ready is low the result holds; one more item is taken into
// the input register, then in_i.ready drops until the result moves on.
// Reset: all lamps off, counters cleared, registers at their default values,
// shutdown code running. A shutdown holds until the next reset.
module keyboard_status_led_sequencer_core #(
  parameter int BreathSteps = kslseq_pkg::BreathStepsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  kslseq_item_if.sink      in_i,
  kslseq_result_if.source  out_o,
  kslseq_cfg_if.sink       cfg_i
);

  kslseq_pkg::cfg_t    cfg_q;
  kslseq_pkg::item_t   item_q;
  kslseq_pkg::result_t step_res;
  kslseq_pkg::result_t res_q;
  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                out_adv;
  logic                s1_adv;
  logic                in_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_off_ticks      <= kslseq_pkg::PowerOffTicksRst;
      cfg_q.pair_arm_ticks       <= kslseq_pkg::PairArmTicksRst;
      cfg_q.pair_timeout_ticks   <= kslseq_pkg::PairTimeoutTicksRst;
      cfg_q.status_divider       <= kslseq_pkg::StatusDividerRst;
      cfg_q.boot_display_periods <= kslseq_pkg::BootDisplayRst;
      cfg_q.low_battery_pct      <= kslseq_pkg::LowBatteryPctRst;
      cfg_q.critical_battery_pct <= kslseq_pkg::CritBatteryPctRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        kslseq_pkg::CfgPowerOffTicks:    cfg_q.power_off_ticks      <= cfg_i.wdata[7:0];
        kslseq_pkg::CfgPairArmTicks:     cfg_q.pair_arm_ticks       <= cfg_i.wdata[7:0];
        kslseq_pkg::CfgPairTimeoutTicks: cfg_q.pair_timeout_ticks   <= cfg_i.wdata;
        kslseq_pkg::CfgStatusDivider:    cfg_q.status_divider       <= cfg_i.wdata[3:0];
        kslseq_pkg::CfgBootDisplay:      cfg_q.boot_display_periods <= cfg_i.wdata[6:0];
        kslseq_pkg::CfgLowBatteryPct:    cfg_q.low_battery_pct      <= cfg_i.wdata[6:0];
        kslseq_pkg::CfgCritBatteryPct:   cfg_q.critical_battery_pct <= cfg_i.wdata[6:0];
        default: ;
      endcase
    end
  end

  // two-stage flow: input register, then result register
  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)      s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_adv)           out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_i.item;
    if (s1_adv) res_q  <= step_res;
  end

  kslseq_step #(
    .BreathSteps(BreathSteps)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .res_o  (step_res)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.result = res_q;

`ifndef NO_ASSERTIONS
  // a shutdown result shows everything dark
  a_halt_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.shutdown_code != kslseq_pkg::HaltRun |->
      !res_q.bt_lamp && !res_q.red_lamp && !res_q.green_lamp && !res_q.mute_lamp &&
      !res_q.mic_lamp && res_q.power_duty == 7'd0 && !res_q.pairing_on)
    else $error("lamp lit during shutdown");

  a_bonds_pairing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.clear_bonds |-> res_q.pairing_on)
    else $error("clear_bonds without pairing");

  // a waiting item stays in the input register until the result register frees
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(item_q))
    else $error("input register lost an item");
`endif

endmodule

// File: test/testbench.sv
// Self-checking bench for the keyboard status lamp sequencer: a lamp scoreboard
// predicts every result from the accepted ticks; plain tasks drive the channels.
// Depends on kslseq_pkg, kslseq_if and keyboard_status_led_sequencer_core.
`timescale 1ns / 100ps

class lamp_scoreboard;
  kslseq_pkg::cfg_t             regs;
  logic [7:0]                   press_cnt;
  logic [7:0]                   arm_cnt;
  logic [11:0]                  pair_left;
  logic                         pairing;
  logic                         was_pairing;
  logic                         blink;
  logic                         bt_toggle;
  logic [3:0]                   phase;
  logic [6:0]                   periods;
  logic [5:0]                   breath_idx;
  logic [kslseq_pkg::LampW-1:0] lamps;
  kslseq_pkg::halt_e            halt;
  logic [6:0]                   curve [20];
  kslseq_pkg::result_t          lamp_words_due [$];
  int                           errors;

  function new();
    curve = '{7'd0, 7'd2, 7'd8, 7'd18, 7'd32, 7'd50, 7'd68, 7'd82, 7'd92, 7'd98,
              7'd100, 7'd98, 7'd92, 7'd82, 7'd68, 7'd50, 7'd32, 7'd18, 7'd8, 7'd2};
    regs.power_off_ticks      = 8'd100;
    regs.pair_arm_ticks       = 8'd25;
    regs.pair_timeout_ticks   = 12'd1125;
    regs.status_divider       = 4'd6;
    regs.boot_display_periods = 7'd10;
    regs.low_battery_pct      = 7'd10;
    regs.critical_battery_pct = 7'd2;
    press_cnt    = '0;
    arm_cnt      = '0;
    pair_left    = '0;
    pairing      = 1'b0;
    was_pairing  = 1'b0;
    blink        = 1'b0;
    bt_toggle    = 1'b0;
    phase        = '0;
    periods      = '0;
    breath_idx   = '0;
    lamps        = '0;
    halt         = kslseq_pkg::HaltRun;
    errors       = 0;
  endfunction

  function void write_reg(kslseq_pkg::cfg_reg_e idx, logic [kslseq_pkg::CfgDataW-1:0] val);
    case (idx)
      kslseq_pkg::CfgPowerOffTicks:    regs.power_off_ticks      = val[7:0];
      kslseq_pkg::CfgPairArmTicks:     regs.pair_arm_ticks       = val[7:0];
      kslseq_pkg::CfgPairTimeoutTicks: regs.pair_timeout_ticks   = val[11:0];
      kslseq_pkg::CfgStatusDivider:    regs.status_divider       = val[3:0];
      kslseq_pkg::CfgBootDisplay:      regs.boot_display_periods = val[6:0];
      kslseq_pkg::CfgLowBatteryPct:    regs.low_battery_pct      = val[6:0];
      kslseq_pkg::CfgCritBatteryPct:   regs.critical_battery_pct = val[6:0];
      default: ;
    endcase
  endfunction

  function void note_tick(kslseq_pkg::item_t it);
    kslseq_pkg::result_t exp_r;
    logic                bonds;
    logic                low;
    logic [6:0]          duty;
    logic [3:0]          div;
    exp_r = '0;
    bonds = 1'b0;
    if (halt == kslseq_pkg::HaltRun) begin
      if (it.mute_key_press) lamps[kslseq_pkg::LampMute] = ~lamps[kslseq_pkg::LampMute];
      if (it.mic_key_press) lamps[kslseq_pkg::LampMic] = ~lamps[kslseq_pkg::LampMic];
      if (it.power_key_down) begin
        if (press_cnt != kslseq_pkg::CountMax) press_cnt++;
        if (press_cnt >= regs.power_off_ticks) halt = kslseq_pkg::HaltManual;
      end else begin
        press_cnt = '0;
      end
      if (halt == kslseq_pkg::HaltRun &&
          it.battery_level < regs.critical_battery_pct && !it.usb_power)
        halt = kslseq_pkg::HaltBattery;
    end
    // Shutdown latches: everything dark except the code
    if (halt != kslseq_pkg::HaltRun) begin
      lamps = '0;
      pairing = 1'b0;
      exp_r.shutdown_code = halt;
      lamp_words_due.push_back(exp_r);
      return;
    end

    if (!pairing) begin
      if (it.fn_layer_held && it.power_key_down) begin
        if (arm_cnt == 0) begin
          arm_cnt = 8'd1;
        end else if (arm_cnt >= regs.pair_arm_ticks) begin
          pairing = 1'b1;
          bonds = 1'b1;
          pair_left = regs.pair_timeout_ticks;
          arm_cnt = '0;
        end else if (arm_cnt != kslseq_pkg::CountMax) begin
          arm_cnt++;
        end
      end else begin
        arm_cnt = '0;
      end
    end else begin
      if (pair_left != 0) pair_left--;
      if (it.link_up || pair_left == 0) pairing = 1'b0;
    end

    if (was_pairing && !pairing) begin
      lamps[kslseq_pkg::LampMute] = 1'b0;
      lamps[kslseq_pkg::LampMic] = 1'b0;
    end
    was_pairing = pairing;

    if (pairing) begin
      blink = ~blink;
      lamps[kslseq_pkg::LampBt] = blink;
      lamps[kslseq_pkg::LampMute] = blink;
      lamps[kslseq_pkg::LampMic] = blink;
      duty = blink ? 7'd100 : 7'd0;
      breath_idx = '0;
    end else begin
      if (breath_idx >= kslseq_pkg::BreathStepsDefault) breath_idx = '0;
      duty = (breath_idx < 20) ? curve[breath_idx] : 7'd0;
      breath_idx++;
      if (breath_idx >= kslseq_pkg::BreathStepsDefault) breath_idx = '0;
    end

    div = (regs.status_divider == 0) ? 4'd1 : regs.status_divider;
    if (phase >= div) phase = '0;
    if (phase == 0 && !pairing) begin
      if (it.device_idle) lamps[kslseq_pkg::LampBt] = 1'b0;
      else if (it.link_up) lamps[kslseq_pkg::LampBt] = 1'b1;
      else lamps[kslseq_pkg::LampBt] = bt_toggle;
      if (it.usb_power) begin
        lamps[kslseq_pkg::LampRed] = it.charger_busy;
        lamps[kslseq_pkg::LampGreen] = !it.charger_busy;
      end else if (periods < regs.boot_display_periods && !it.device_idle) begin
        low = it.battery_level < regs.low_battery_pct;
        lamps[kslseq_pkg::LampRed] = low;
        lamps[kslseq_pkg::LampGreen] = !low;
      end else begin
        lamps[kslseq_pkg::LampRed] = 1'b0;
        lamps[kslseq_pkg::LampGreen] = 1'b0;
      end
      bt_toggle = ~bt_toggle;
    end
    phase++;
    if (phase >= div) begin
      phase = '0;
      if (periods != kslseq_pkg::PeriodsMax) periods++;
    end

    exp_r.bt_lamp     = lamps[kslseq_pkg::LampBt];
    exp_r.red_lamp    = lamps[kslseq_pkg::LampRed];
    exp_r.green_lamp  = lamps[kslseq_pkg::LampGreen];
    exp_r.mute_lamp   = lamps[kslseq_pkg::LampMute];
    exp_r.mic_lamp    = lamps[kslseq_pkg::LampMic];
    exp_r.power_duty  = duty;
    exp_r.pairing_on  = pairing;
    exp_r.clear_bonds = bonds;
    lamp_words_due.push_back(exp_r);
  endfunction

  function void check_field(string name, logic [6:0] exp_v, logic [6:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= 10) $display("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  function void check_result(kslseq_pkg::result_t got);
    kslseq_pkg::result_t exp_r;
    if (lamp_words_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result with no tick pending: %h", got);
      return;
    end
    exp_r = lamp_words_due.pop_front();
    check_field("bt_lamp", exp_r.bt_lamp, got.bt_lamp);
    check_field("red_lamp", exp_r.red_lamp, got.red_lamp);
    check_field("green_lamp", exp_r.green_lamp, got.green_lamp);
    check_field("mute_lamp", exp_r.mute_lamp, got.mute_lamp);
    check_field("mic_lamp", exp_r.mic_lamp, got.mic_lamp);
    check_field("power_duty", exp_r.power_duty, got.power_duty);
    check_field("shutdown_code", exp_r.shutdown_code, got.shutdown_code);
    check_field("pairing_on", exp_r.pairing_on, got.pairing_on);
    check_field("clear_bonds", exp_r.clear_bonds, got.clear_bonds);
  endfunction
endclass

module testbench;
  localparam int CycleLimit = 400000;
  localparam int DataW      = kslseq_pkg::CfgDataW;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   sent;
  int   cycles;

  lamp_scoreboard lamps_sb = new();

  kslseq_item_if   in_if ();
  kslseq_result_if out_if ();
  kslseq_cfg_if    cfg_if ();

  keyboard_status_led_sequencer_core #(
    .BreathSteps(kslseq_pkg::BreathStepsDefault)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic kslseq_pkg::item_t pack_tick(bit pwr, bit fn, bit link, logic [6:0] level,
                                                  bit usb, bit idle, bit chg, bit mute, bit mic);
    kslseq_pkg::item_t it;
    it.power_key_down = pwr;
    it.fn_layer_held  = fn;
    it.link_up        = link;
    it.battery_level  = level;
    it.usb_power      = usb;
    it.device_idle    = idle;
    it.charger_busy   = chg;
    it.mute_key_press = mute;
    it.mic_key_press  = mic;
    return it;
  endfunction

  // Random tick that keeps clear of shutdown: drop the power key before the
  // hold limit and keep the charge at or above the critical level off USB.
  function automatic kslseq_pkg::item_t make_tick(bit pwr, bit fn, bit link);
    kslseq_pkg::item_t it;
    it = pack_tick(pwr, fn, link, 7'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (int'(lamps_sb.press_cnt) + 1 >= int'(lamps_sb.regs.power_off_ticks))
      it.power_key_down = 1'b0;
    if (!it.usb_power && it.battery_level < lamps_sb.regs.critical_battery_pct)
      it.battery_level = 7'($urandom_range(lamps_sb.regs.critical_battery_pct, 100));
    return it;
  endfunction

  task automatic send_tick(kslseq_pkg::item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) steady = ~steady;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    do @(posedge clk_i); while (!in_if.ready);
    lamps_sb.note_tick(it);
    sent++;
  endtask

  // Drop valid and hold until every result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (lamps_sb.lamp_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(kslseq_pkg::cfg_reg_e idx, logic [DataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    lamps_sb.write_reg(idx, val);
  endtask

  task automatic apply_config(int pot, int arm, int tmo, int div, int boot, int low, int crit);
    cfg_write(kslseq_pkg::CfgPowerOffTicks, DataW'(pot));
    cfg_write(kslseq_pkg::CfgPairArmTicks, DataW'(arm));
    cfg_write(kslseq_pkg::CfgPairTimeoutTicks, DataW'(tmo));
    cfg_write(kslseq_pkg::CfgStatusDivider, DataW'(div));
    cfg_write(kslseq_pkg::CfgBootDisplay, DataW'(boot));
    cfg_write(kslseq_pkg::CfgLowBatteryPct, DataW'(low));
    cfg_write(kslseq_pkg::CfgCritBatteryPct, DataW'(crit));
    cfg_if.valid <= 1'b0;
  endtask

  // Setting k: low numbers push registers to their extremes
  task automatic configure(int k);
    int pot, arm, tmo, div, boot, low, crit;
    pot  = (k == 1) ? 255 : $urandom_range(60, 255);
    arm  = (k == 2) ? 255 : (k == 1) ? 1 : $urandom_range(1, 12);
    tmo  = (k == 3) ? 4095 : (k == 1) ? 1 : $urandom_range(1, 40);
    div  = (k == 4) ? 15 : (k == 1) ? 1 : (k == 5) ? 0 : $urandom_range(1, 15);
    boot = (k == 1) ? 0 : (k == 2) ? 127 : $urandom_range(0, 127);
    low  = (k == 1) ? 0 : (k == 3) ? 100 : $urandom_range(0, 100);
    crit = (k == 1) ? 0 : (k == 4) ? 100 : $urandom_range(0, 100);
    apply_config(pot, arm, tmo, div, boot, low, crit);
  endtask

  // Hold fn and power long enough to arm (or cut short), at most 60 ticks, then
  // dwell in pairing until link or timeout ends it.
  task automatic pairing_attempt(bit cut_short);
    int arm, hold, dwell;
    arm = int'(lamps_sb.regs.pair_arm_ticks);
    hold = cut_short ? $urandom_range(1, arm) : arm + 1 + $urandom_range(0, 2);
    if (hold > 60) hold = 60;
    send_tick(make_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0));
    repeat (hold) send_tick(make_tick(1'b1, 1'b1, $urandom_range(0, 7) == 0));
    dwell = 0;
    while (lamps_sb.pairing && dwell < 24) begin
      send_tick(make_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 9) == 0));
      dwell++;
    end
    if (lamps_sb.pairing) send_tick(make_tick(1'b0, 1'b0, 1'b1));
  endtask

  task automatic random_phase(int target);
    int first, pick;
    first = sent;
    while (sent - first < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        pairing_attempt(1'b0);
      end else if (pick == 5) begin
        pairing_attempt(1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
      end
    end
  endtask

  // Trigger the one shutdown of the run: manual, critical battery, or both on
  // the same tick (manual wins); then check that later ticks are ignored.
  task automatic shutdown_ending();
    int                kind, hold, crit;
    kslseq_pkg::item_t it;
    kind = $urandom_range(0, 2);
    hold = $urandom_range(1, 8);
    crit = $urandom_range(1, 100);
    apply_config(hold, $urandom_range(1, 255), $urandom_range(1, 4095), $urandom_range(1, 15),
                 $urandom_range(0, 127), $urandom_range(0, 100), crit);
    it = make_tick(1'b0, 1'b0, 1'b0);
    it.usb_power = 1'b1;
    send_tick(it);
    if (kind != 1) begin
      repeat ((kind == 0) ? hold : hold - 1) begin
        it = make_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        it.power_key_down = 1'b1;
        it.usb_power = 1'b1;
        send_tick(it);
      end
    end
    if (kind != 0) begin
      it = make_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      it.power_key_down = (kind == 2);
      it.usb_power = 1'b0;
      it.battery_level = 7'($urandom_range(0, crit - 1));
      send_tick(it);
    end
    repeat (8) begin
      it = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      it.power_key_down = 1'($urandom_range(0, 1));
      it.usb_power = 1'($urandom_range(0, 1));
      it.battery_level = 7'($urandom_range(0, 100));
      send_tick(it);
    end
  endtask

  // Result side: random stall before each result, none in steady stretches
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      lamps_sb.check_result(out_if.result);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.addr <= kslseq_pkg::CfgPowerOffTicks;
    cfg_if.wdata <= '0;
    steady = 1'b0;
    sent = 0;
    cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: lamp toggles, boot battery display, supply states
    send_tick(pack_tick(0, 0, 0, 7'd50, 0, 0, 0, 1, 0));
    send_tick(pack_tick(0, 0, 0, 7'd50, 0, 0, 0, 0, 1));
    send_tick(pack_tick(0, 0, 0, 7'd5, 0, 0, 0, 1, 1));
    send_tick(pack_tick(0, 0, 1, 7'd100, 1, 0, 1, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd0, 1, 1, 0, 0, 0));
    send_tick(pack_tick(1, 0, 0, 7'd2, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 1, 0, 7'd64, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd63, 1, 0, 0, 0, 0));
    wait_drained();

    // Quick pairing: enter on the second hold tick, exit on timeout, then on link
    apply_config(200, 1, 3, 1, 3, 50, 5);
    send_tick(pack_tick(1, 1, 0, 7'd60, 0, 0, 0, 0, 0));
    send_tick(pack_tick(1, 1, 0, 7'd60, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd49, 0, 0, 0, 1, 0));
    send_tick(pack_tick(0, 0, 0, 7'd50, 0, 0, 0, 0, 1));
    send_tick(pack_tick(0, 0, 0, 7'd5, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd4, 1, 0, 1, 0, 0));
    send_tick(pack_tick(1, 1, 0, 7'd99, 1, 0, 0, 0, 0));
    send_tick(pack_tick(1, 1, 1, 7'd99, 1, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 1, 7'd99, 1, 0, 0, 1, 1));
    send_tick(pack_tick(0, 0, 0, 7'd100, 0, 1, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd100, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 7'd6, 0, 0, 0, 0, 0));

    for (int k = 1; k <= 6; k++) begin
      wait_drained();
      configure(k);
      random_phase(85);
    end
    wait_drained();
    shutdown_ending();
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (lamps_sb.errors == 0 && lamps_sb.lamp_words_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
